// ----- design/pet_pkg.sv -----
// Shared constants and types for the Prewitt edge threshold block.
`default_nettype none
package pet_pkg;

    localparam int WIDTH  = 512;
    localparam int HEIGHT = 512;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int THR_W  = 10;

    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);
    localparam int PEND_W = $clog2(WIDTH + 2);

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);
    localparam logic [PIX_W-1:0] EDGE_ON   = PIX_W'(255);
    localparam logic [PIX_W-1:0] EDGE_OFF  = PIX_W'(0);

    typedef struct packed {
        logic [2:0][PIX_W-1:0] left;
        logic [2:0][PIX_W-1:0] right;
    } t_cols;

    typedef struct packed {
        logic [PIX_W-1:0]         edge_pixel;
        logic signed [GRAD_W-1:0] gradient;
        logic                     frame_end;
    } t_result;

endpackage
`default_nettype wire

// ----- design/pet_line_buf.sv -----
// Two-line pixel store and the left and right window columns.
`default_nettype none
module pet_line_buf (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire  [pet_pkg::PIX_W-1:0]      i_pixel,
    output pet_pkg::t_cols                 o_cols
);
    import pet_pkg::*;

    logic [2*PIX_W-1:0]      r_line_mem [WIDTH];
    logic [2*PIX_W-1:0]      r_rd;
    logic [PIX_W-1:0]        r_new;
    logic [COL_W-1:0]        r_ptr;
    logic [COL_W-1:0]        n_ptr;
    logic [COL_W-1:0]        r_wr_addr;
    logic                    r_wr_pend;
    logic [2:0][PIX_W-1:0]   cur;
    logic [2:0][PIX_W-1:0]   r_d1;
    logic [2:0][PIX_W-1:0]   r_d2;

    assign cur[0] = r_rd[2*PIX_W-1:PIX_W];
    assign cur[1] = r_rd[PIX_W-1:0];
    assign cur[2] = r_new;

    assign n_ptr = (r_ptr == COL_W'(WIDTH - 1)) ? '0 : r_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_en;
            if (i_en) begin
                r_ptr <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd      <= r_line_mem[r_ptr];
            r_new     <= i_pixel;
            r_wr_addr <= r_ptr;
            r_d1      <= cur;
            r_d2      <= r_d1;
        end
        if (r_wr_pend) begin
            r_line_mem[r_wr_addr] <= {r_rd[PIX_W-1:0], r_new};
        end
    end

    assign o_cols.right = cur;
    assign o_cols.left  = r_d2;

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pend && i_en) |-> (r_wr_addr != r_ptr))
        else $error("Line store write and read hit the same address.");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= COL_W'(WIDTH - 1))
        else $error("Line store pointer out of range.");
`endif

endmodule
`default_nettype wire

// ----- design/pet_out_fifo.sv -----
// Small result queue that decouples the output from the pixel pipeline.
`default_nettype none
module pet_out_fifo (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_push,
    input  pet_pkg::t_result                  i_data,
    output logic                              o_valid,
    input  wire                               i_stall,
    output pet_pkg::t_result                  o_data,
    output logic [pet_pkg::FIFO_CNT_W-1:0]    o_count
);
    import pet_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wptr;
    logic [FIFO_PTR_W-1:0]  r_rptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("Result queue overflow.");
`endif

endmodule
`default_nettype wire

// ----- design/prewitt_edge_threshold.sv -----
// Top level of the Prewitt horizontal-gradient edge detector with threshold.
// Pixels enter in raster order on i_valid/o_stall, one word per item; a word
// with i_is_pad set counts as a zero pixel. After each frame the source sends
// WIDTH+1 pad words so that the last results drain out.
// Results leave on o_valid/i_stall. The result for a pixel is caused by the
// word that arrives WIDTH+1 words later. With an empty queue it is computed in
// the compare stage and registered into the result queue, which drives the output.
// The first WIDTH+1 words of a frame give no result.
// One word is taken per clock while o_stall is low: the line store is one RAM
// read once and written once per word, and the gradient and threshold compare
// sit in one stage between the window registers and a three-entry result queue.
// When the receiver stalls, the queue absorbs results in flight and o_stall
// rises once the queued results plus the one in the compare stage reach three.
// The threshold is written on i_cfg_valid/o_cfg_ready, which is always ready;
// the user must write it only while the block is idle, which is not enforced.
// Synchronous reset clears the counters and the queue and sets the threshold
// to 50. The line store is not cleared; rows above the frame are masked.
`default_nettype none
module prewitt_edge_threshold (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [pet_pkg::PIX_W-1:0]           i_pixel_value,
    input  wire                                 i_is_pad,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [pet_pkg::PIX_W-1:0]           o_edge_pixel,
    output logic signed [pet_pkg::GRAD_W-1:0]   o_gradient,
    output logic                                o_frame_end,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [pet_pkg::THR_W-1:0]           i_cfg_data
);
    import pet_pkg::*;

    logic                     accept;
    logic [PIX_W-1:0]         pix;
    t_cols                    cols;
    t_result                  res;
    t_result                  q_data;
    logic [FIFO_CNT_W-1:0]    q_count;

    logic [THR_W-1:0]         r_thr;
    logic [PEND_W-1:0]        r_pend;
    logic [COL_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;
    logic                     produce;
    logic                     last;

    logic                     r_s1_valid;
    logic                     r_s1_top_ok;
    logic                     r_s1_bot_ok;
    logic                     r_s1_left_ok;
    logic                     r_s1_right_ok;
    logic                     r_s1_last;

    logic [PIX_W+1:0]         sum_l;
    logic [PIX_W+1:0]         sum_r;
    logic [2:0]               row_ok;
    logic signed [GRAD_W-1:0] grad;
    logic [GRAD_W-1:0]        mag;

    assign o_stall     = ({1'b0, q_count} + {{FIFO_CNT_W{1'b0}}, r_s1_valid})
                         > (FIFO_CNT_W+1)'(FIFO_DEPTH - 1);
    assign accept      = i_valid && !o_stall;
    assign pix         = i_is_pad ? '0 : i_pixel_value;
    assign o_cfg_ready = 1'b1;

    assign produce = (r_pend == PEND_W'(WIDTH + 1));
    assign last    = (r_row == ROW_W'(HEIGHT - 1)) && (r_col == COL_W'(WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_pend     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            r_s1_valid <= accept && produce;
            if (accept) begin
                if (!produce) begin
                    r_pend <= r_pend + 1'b1;
                end else if (last) begin
                    r_pend <= '0;
                    r_col  <= '0;
                    r_row  <= '0;
                end else if (r_col == COL_W'(WIDTH - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_top_ok   <= (r_row != '0);
            r_s1_bot_ok   <= (r_row != ROW_W'(HEIGHT - 1));
            r_s1_left_ok  <= (r_col != '0);
            r_s1_right_ok <= (r_col != COL_W'(WIDTH - 1));
            r_s1_last     <= last;
        end
    end

    pet_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_pixel (pix),
        .o_cols  (cols)
    );

    assign row_ok = {r_s1_bot_ok, 1'b1, r_s1_top_ok};

    always_comb begin
        sum_l = '0;
        sum_r = '0;
        for (int i = 0; i < 3; i++) begin
            if (row_ok[i] && r_s1_left_ok) begin
                sum_l = sum_l + {2'b00, cols.left[i]};
            end
            if (row_ok[i] && r_s1_right_ok) begin
                sum_r = sum_r + {2'b00, cols.right[i]};
            end
        end
        grad = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        mag  = grad[GRAD_W-1] ? GRAD_W'(-grad) : GRAD_W'(grad);
        res.gradient   = grad;
        res.edge_pixel = (mag >= {1'b0, r_thr}) ? EDGE_ON : EDGE_OFF;
        res.frame_end  = r_s1_last;
    end

    pet_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_edge_pixel = q_data.edge_pixel;
    assign o_gradient   = q_data.gradient;
    assign o_frame_end  = q_data.frame_end;

`ifndef SYNTHESIS
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(WIDTH + 1))
        else $error("Pending count beyond the line lag.");
    a_coords_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_W'(WIDTH - 1)) && (r_row <= ROW_W'(HEIGHT - 1)))
        else $error("Pixel coordinates out of the frame.");
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> (!r_s1_bot_ok && !r_s1_right_ok))
        else $error("Frame end flagged away from the bottom right corner.");
    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> (r_pend == $past(r_pend) && r_col == $past(r_col)))
        else $error("Counters moved without an accepted word.");
`endif

endmodule
`default_nettype wire

// ----- tb/prewitt_edge_threshold_checker.sv -----
// Checker that predicts the edge results from the pixel words it sees and compares them.
module prewitt_edge_threshold_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_pix_valid,
    input  wire                              i_pix_stall,
    input  wire [pet_pkg::PIX_W-1:0]         i_pixel_value,
    input  wire                              i_is_pad,
    input  wire                              i_res_valid,
    input  wire                              i_res_stall,
    input  wire [pet_pkg::PIX_W-1:0]         i_edge_pixel,
    input  wire signed [pet_pkg::GRAD_W-1:0] i_gradient,
    input  wire                              i_frame_end,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire [pet_pkg::THR_W-1:0]         i_cfg_data,
    output int                               o_mismatches,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pet_pkg::*;

    localparam int HIST_D = 2 * WIDTH + 3;

    logic [PIX_W-1:0] pixel_hist [HIST_D];
    int               hist_head;
    int               col_pos;
    int               row_pos;
    int               warmup;
    logic [THR_W-1:0] threshold;
    t_result          edge_expected [$];
    t_result          want;
    int               mismatches;

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] wanted);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, wanted);
        mismatches++;
    endtask

    function automatic void predict_edge(input logic [PIX_W-1:0] pix, input logic pad);
        int             grad;
        int             mag;
        int             back;
        int             i;
        int             j;
        bit             row_ok;
        bit             col_ok;
        logic [PIX_W-1:0] s;
        t_result        res;
        hist_head = (hist_head + 1) % HIST_D;
        pixel_hist[hist_head] = pad ? '0 : pix;
        if (warmup < WIDTH + 1) begin
            warmup++;
            return;
        end
        grad = 0;
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j += 2) begin
                row_ok = (i == 0) ? (row_pos >= 1) : (i == 2) ? (row_pos + 1 < HEIGHT) : 1'b1;
                col_ok = (j == 0) ? (col_pos >= 1) : (col_pos + 1 < WIDTH);
                back = (2 - i) * WIDTH + (2 - j);
                s = (row_ok && col_ok) ? pixel_hist[(hist_head + HIST_D - back) % HIST_D] : '0;
                grad += (j == 0) ? int'(s) : -int'(s);
            end
        end
        mag = (grad < 0) ? -grad : grad;
        res.edge_pixel = (mag >= int'(threshold)) ? EDGE_ON : EDGE_OFF;
        res.gradient   = GRAD_W'(grad);
        res.frame_end  = (row_pos == HEIGHT - 1) && (col_pos == WIDTH - 1);
        edge_expected.push_back(res);
        if (res.frame_end) begin
            row_pos = 0;
            col_pos = 0;
            warmup  = 0;
        end else begin
            col_pos++;
            if (col_pos == WIDTH) begin
                col_pos = 0;
                row_pos++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_D; k++) pixel_hist[k] = '0;
            hist_head = 0;
            col_pos   = 0;
            row_pos   = 0;
            warmup    = 0;
            threshold = THR_RESET;
            edge_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                threshold = i_cfg_data;
            if (i_pix_valid && !i_pix_stall)
                predict_edge(i_pixel_value, i_is_pad);
            if (i_res_valid && !i_res_stall) begin
                if (edge_expected.size() == 0) begin
                    report_mismatch("result with no word expected", i_gradient, 0);
                end else begin
                    want = edge_expected.pop_front();
                    if (i_edge_pixel !== want.edge_pixel)
                        report_mismatch("edge_pixel", i_edge_pixel, want.edge_pixel);
                    if (i_gradient !== want.gradient)
                        report_mismatch("gradient", i_gradient, want.gradient);
                    if (i_frame_end !== want.frame_end)
                        report_mismatch("frame_end", i_frame_end, want.frame_end);
                end
            end
        end
        o_pending    <= edge_expected.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- tb/prewitt_edge_threshold_tb.sv -----
// Testbench top that streams pixel words into the edge detector and gives the verdict.
module prewitt_edge_threshold_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pet_pkg::*;

    typedef enum int {TEX_NOISE, TEX_STEP, TEX_FLAT, TEX_RAMP, TEX_HOLES} t_texture;

    localparam int N_ITEMS    = 640;
    localparam int SEG        = 64;
    localparam int THR_FIRST  = 530;
    localparam int THR_STEP   = 10;
    localparam int THR_LOADS  = 7;
    localparam int QUIET_FROM = 600;
    localparam int HOLD_LEN   = 60;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [PIX_W-1:0]         i_pixel_value;
    logic                     i_is_pad;
    logic                     o_valid;
    logic                     i_stall;
    logic [PIX_W-1:0]         o_edge_pixel;
    logic signed [GRAD_W-1:0] o_gradient;
    logic                     o_frame_end;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [THR_W-1:0]         i_cfg_data;
    int                       mismatches;
    int                       pending;
    bit                       idle_on = 1'b1;

    prewitt_edge_threshold dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .i_is_pad      (i_is_pad),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_edge_pixel  (o_edge_pixel),
        .o_gradient    (o_gradient),
        .o_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    prewitt_edge_threshold_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pixel_value (i_pixel_value),
        .i_is_pad      (i_is_pad),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_edge_pixel  (o_edge_pixel),
        .i_gradient    (o_gradient),
        .i_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic pad);
        int gap;
        if (idle_on && $urandom_range(0, 31) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        i_is_pad      <= pad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic load_threshold(input logic [THR_W-1:0] thr);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver holds off once, as soon as results start, so the result queue fills.
    initial begin
        int  gap;
        int  hold;
        bit  held;
        held   = 1'b0;
        i_stall <= 1'b0;
        forever begin
            if (!held && o_valid === 1'b1) begin
                held = 1'b1;
                i_stall <= 1'b1;
                for (hold = 0; hold < HOLD_LEN; hold++) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 31) == 0) begin
                gap = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int               thr_plan [7];
        int               n;
        int               c;
        t_texture         tex;
        int               band_col;
        bit               band_flip;
        logic [PIX_W-1:0] band_level;
        int               band_slope;
        logic [PIX_W-1:0] pix;
        logic             pad;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pixel_value <= '0;
        i_is_pad      <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        thr_plan = '{0, 1023, 765, 766, 1, $urandom_range(2, 764), $urandom_range(767, 1022)};
        tex = TEX_NOISE;
        band_col = 0;
        band_flip = 1'b0;
        band_level = '0;
        band_slope = 1;
        for (int k = 0; k < N_ITEMS; k++) begin
            c = k % WIDTH;
            if (k >= THR_FIRST && (k - THR_FIRST) % THR_STEP == 0
                && (k - THR_FIRST) / THR_STEP < THR_LOADS)
                load_threshold(THR_W'(thr_plan[(k - THR_FIRST) / THR_STEP]));
            if (k == QUIET_FROM)
                idle_on = 1'b0;
            if (k % SEG == 0) begin
                tex        = t_texture'($urandom_range(0, 4));
                band_col   = $urandom_range(0, WIDTH);
                band_flip  = $urandom_range(0, 1);
                band_level = ($urandom_range(0, 2) == 0) ? 8'hFF :
                             ($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
                band_slope = $urandom_range(1, 16);
                // Full-scale steps at the start of each row give large gradient magnitudes
                // and hit the masking at the left border.
                if (c == 0) begin
                    tex = TEX_STEP;
                    band_col = SEG / 2;
                    band_flip = 1'b0;
                end
            end
            pad = (tex == TEX_HOLES) ? ($urandom_range(0, 3) == 0)
                                     : ($urandom_range(0, 63) == 0);
            case (tex)
                TEX_NOISE: pix = 8'($urandom_range(0, 255));
                TEX_STEP:  pix = ((c < band_col) ^ band_flip) ? 8'hFF : 8'h00;
                TEX_FLAT:  pix = band_level;
                TEX_RAMP:  pix = 8'(c * band_slope);
                default:   pix = 8'hFF;
            endcase
            offer_pixel(pix, pad);
        end
        i_valid <= 1'b0;
        for (n = 0; n < 10000 && pending != 0; n++) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
